// ----- src/vepm_pkg.sv -----
// Package for the envelope and peak level meter: payload words, configuration
// set, controller states and the command word from controller to datapath.
// Used by every module of the block; it depends on nothing.
package vepm_pkg;

   // Input word: raw level and three band levels, all unsigned Q4.12.
   typedef struct packed {
      logic [15:0] raw_level;
      logic [15:0] bass_level;
      logic [15:0] mid_level;
      logic [15:0] treble_level;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [5:0]  level_height;
      logic [6:0]  bass_bar;
      logic [6:0]  mid_bar;
      logic [6:0]  treble_bar;
      logic [15:0] smoothed_out;
      logic [15:0] peak_out;
   } rsp_type;

   // Configuration registers as seen by the datapath.
   typedef struct packed {
      logic [15:0] attack_coef;
      logic [15:0] release_coef;
      logic [15:0] peak_decay;
      logic [5:0]  meter_height;
      logic [6:0]  bar_span;
      logic [15:0] band_full_scale;
   } cfg_type;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPAN       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [15:0] ATTACK_RESET     = 16'd26214;
   localparam logic [15:0] RELEASE_RESET    = 16'd1311;
   localparam logic [15:0] DECAY_RESET      = 16'd65470;
   localparam logic [5:0]  HEIGHT_RESET     = 6'd55;
   localparam logic [6:0]  SPAN_RESET       = 7'd110;
   localparam logic [15:0] FULL_SCALE_RESET = 16'd16384;

   // Peak state after reset: 0.01 in Q4.28.
   localparam logic [31:0] PEAK_RESET = 32'd2684355;

   // Divider: seven quotient bits, one per step.
   localparam int unsigned DIV_STEPS  = 7;
   localparam int unsigned DIV_STEP_W = 3;
   localparam int unsigned REM_W      = 38;

   // Which division the shared divider is working on.
   localparam logic [1:0] SEL_LEVEL  = 2'd0;
   localparam logic [1:0] SEL_BASS   = 2'd1;
   localparam logic [1:0] SEL_MID    = 2'd2;
   localparam logic [1:0] SEL_TREBLE = 2'd3;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SMOOTH,
      ST_UPD_SMOOTH,
      ST_MUL_PEAK,
      ST_UPD_PEAK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_in;
      logic       mul_smooth;
      logic       upd_smooth;
      logic       mul_peak;
      logic       upd_peak;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic       rsp_load;
      logic [1:0] sel;
   } cmd_type;

endpackage

// ----- src/vepm_csr.sv -----
// Configuration registers of the level meter, written over the csr channel.
// Depends on vepm_pkg.
module vepm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vepm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [15:0]                        csr_data,
   output vepm_pkg::cfg_type                  cfg
);

   vepm_pkg::cfg_type cfg_ff;
   vepm_pkg::cfg_type cfg_in;

   // The register file is always ready for a word.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the index; an index past the list leaves everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vepm_pkg::CSR_ATTACK:     cfg_in.attack_coef     = csr_data;
            vepm_pkg::CSR_RELEASE:    cfg_in.release_coef    = csr_data;
            vepm_pkg::CSR_DECAY:      cfg_in.peak_decay      = csr_data;
            vepm_pkg::CSR_HEIGHT:     cfg_in.meter_height    = csr_data[5:0];
            vepm_pkg::CSR_SPAN:       cfg_in.bar_span        = csr_data[6:0];
            vepm_pkg::CSR_FULL_SCALE: cfg_in.band_full_scale = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coef     <= vepm_pkg::ATTACK_RESET;
         cfg_ff.release_coef    <= vepm_pkg::RELEASE_RESET;
         cfg_ff.peak_decay      <= vepm_pkg::DECAY_RESET;
         cfg_ff.meter_height    <= vepm_pkg::HEIGHT_RESET;
         cfg_ff.bar_span        <= vepm_pkg::SPAN_RESET;
         cfg_ff.band_full_scale <= vepm_pkg::FULL_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/vepm_ctrl.sv -----
// Controller of the level meter: sequences the smoothing, peak and four
// divisions, and owns the input and result handshakes. Depends on vepm_pkg.
module vepm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vepm_pkg::cmd_type cmd
);

   vepm_pkg::state_type             state_ff;
   vepm_pkg::state_type             state_in;
   logic [1:0]                      sel_ff;
   logic [1:0]                      sel_in;
   logic [vepm_pkg::DIV_STEP_W-1:0] step_ff;
   logic [vepm_pkg::DIV_STEP_W-1:0] step_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            last_step;
   logic                            out_free;

   assign last_step = (step_ff == vepm_pkg::DIV_STEP_W'(vepm_pkg::DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == vepm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vepm_pkg::ST_IDLE:       if (req_valid) state_in = vepm_pkg::ST_MUL_SMOOTH;
         vepm_pkg::ST_MUL_SMOOTH: state_in = vepm_pkg::ST_UPD_SMOOTH;
         vepm_pkg::ST_UPD_SMOOTH: state_in = vepm_pkg::ST_MUL_PEAK;
         vepm_pkg::ST_MUL_PEAK:   state_in = vepm_pkg::ST_UPD_PEAK;
         vepm_pkg::ST_UPD_PEAK:   state_in = vepm_pkg::ST_DIV_LOAD;
         vepm_pkg::ST_DIV_LOAD:   state_in = vepm_pkg::ST_DIV_STEP;
         vepm_pkg::ST_DIV_STEP:   if (last_step) state_in = vepm_pkg::ST_DIV_STORE;
         vepm_pkg::ST_DIV_STORE: begin
            if (sel_ff == vepm_pkg::SEL_TREBLE) state_in = vepm_pkg::ST_RESPOND;
            else                                state_in = vepm_pkg::ST_DIV_LOAD;
         end
         vepm_pkg::ST_RESPOND:    if (out_free) state_in = vepm_pkg::ST_IDLE;
         default:                 state_in = vepm_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd            = '0;
      cmd.sel        = sel_ff;
      cmd.load_in    = (state_ff == vepm_pkg::ST_IDLE) && req_valid;
      cmd.mul_smooth = (state_ff == vepm_pkg::ST_MUL_SMOOTH);
      cmd.upd_smooth = (state_ff == vepm_pkg::ST_UPD_SMOOTH);
      cmd.mul_peak   = (state_ff == vepm_pkg::ST_MUL_PEAK);
      cmd.upd_peak   = (state_ff == vepm_pkg::ST_UPD_PEAK);
      cmd.div_load   = (state_ff == vepm_pkg::ST_DIV_LOAD);
      cmd.div_step   = (state_ff == vepm_pkg::ST_DIV_STEP);
      cmd.div_store  = (state_ff == vepm_pkg::ST_DIV_STORE);
      cmd.rsp_load   = (state_ff == vepm_pkg::ST_RESPOND) && out_free;
   end

   // Division select, step counter and result valid flag.
   always_comb begin
      sel_in       = sel_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_in)   sel_in  = vepm_pkg::SEL_LEVEL;
      if (cmd.div_store) sel_in  = sel_ff + 2'd1;
      if (cmd.div_load)  step_in = '0;
      if (cmd.div_step)  step_in = step_ff + vepm_pkg::DIV_STEP_W'(1);
      if (cmd.rsp_load)              rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vepm_pkg::ST_IDLE;
         sel_ff       <= vepm_pkg::SEL_LEVEL;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted word always starts the smoothing multiply.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == vepm_pkg::ST_MUL_SMOOTH)
      else $error("accepted word did not start the smoothing step");

   // A division is stored only after its full run of steps.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == vepm_pkg::ST_DIV_STORE |->
         $past(state_ff) == vepm_pkg::ST_DIV_STEP &&
         $past(step_ff) == vepm_pkg::DIV_STEP_W'(vepm_pkg::DIV_STEPS - 1))
      else $error("division stored before its last step");

   // A result appears only from the respond state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == vepm_pkg::ST_RESPOND)
      else $error("result valid raised outside the respond state");

endmodule

// ----- src/vepm_dp.sv -----
// Datapath of the level meter: envelope and peak state, the multipliers,
// a shared shift-subtract divider and the result register. Depends on vepm_pkg.
module vepm_dp (
   input  logic              clock,
   input  logic              reset,
   input  vepm_pkg::cmd_type cmd,
   input  vepm_pkg::cfg_type cfg,
   input  vepm_pkg::req_type req_data,
   output vepm_pkg::rsp_type rsp_data
);

   vepm_pkg::req_type         in_ff;
   vepm_pkg::req_type         in_in;
   logic [31:0]               s_ff;
   logic [31:0]               s_in;
   logic [31:0]               p_ff;
   logic [31:0]               p_in;
   logic [31:0]               prod_a_ff;
   logic [31:0]               prod_a_in;
   logic [47:0]               prod_b_ff;
   logic [47:0]               prod_b_in;
   logic [vepm_pkg::REM_W-1:0] rem_ff;
   logic [vepm_pkg::REM_W-1:0] rem_in;
   logic [vepm_pkg::REM_W-1:0] dsh_ff;
   logic [vepm_pkg::REM_W-1:0] dsh_in;
   logic [6:0]                quo_ff;
   logic [6:0]                quo_in;
   vepm_pkg::rsp_type         res_ff;
   vepm_pkg::rsp_type         res_in;
   vepm_pkg::rsp_type         out_ff;
   vepm_pkg::rsp_type         out_in;

   logic [31:0] raw_wide;
   logic        rising;
   logic [15:0] coef;
   logic [16:0] coef_inv;
   logic [31:0] gain_prod;
   logic [48:0] keep_prod;
   logic [47:0] decay_prod;
   logic [32:0] smooth_sum;
   logic [31:0] decayed;
   logic [15:0] band;
   logic        band_full;
   logic [38:0] mul_a;
   logic [38:0] mul_b;
   logic [38:0] mul_p;
   logic [31:0] divisor;
   logic        fits;
   logic [6:0]  bar;

   // Envelope: pick attack or release weight, then weigh new and old level.
   assign raw_wide   = {in_ff.raw_level, 16'h0000};
   assign rising     = raw_wide > s_ff;
   assign coef       = rising ? cfg.attack_coef : cfg.release_coef;
   assign coef_inv   = 17'h10000 - {1'b0, coef};
   assign gain_prod  = {16'h0000, in_ff.raw_level} * {16'h0000, coef};
   assign keep_prod  = {17'h00000, s_ff} * {32'h0, coef_inv};
   assign smooth_sum = {1'b0, prod_a_ff} + {1'b0, prod_b_ff[47:16]};

   // Peak: decay, then never below the smoothed level.
   assign decay_prod = {16'h0000, p_ff} * {32'h0, cfg.peak_decay};
   assign decayed    = prod_b_ff[47:16];

   // Band being worked on by the divider.
   always_comb begin
      unique case (cmd.sel)
         vepm_pkg::SEL_BASS:   band = in_ff.bass_level;
         vepm_pkg::SEL_MID:    band = in_ff.mid_level;
         vepm_pkg::SEL_TREBLE: band = in_ff.treble_level;
         default:              band = in_ff.raw_level;
      endcase
   end
   assign band_full = band >= cfg.band_full_scale;

   // Dividend and divisor for the selected division.
   always_comb begin
      if (cmd.sel == vepm_pkg::SEL_LEVEL) begin
         mul_a   = {7'h00, s_ff};
         mul_b   = {33'h0, cfg.meter_height};
         divisor = p_ff;
      end else begin
         mul_a   = {23'h0, band};
         mul_b   = {32'h0, cfg.bar_span};
         divisor = {16'h0000, cfg.band_full_scale};
      end
   end
   assign mul_p = mul_a * mul_b;

   // One quotient bit per step: compare against the shifted divisor.
   assign fits = rem_ff >= dsh_ff;
   assign bar  = band_full ? cfg.bar_span : quo_ff;

   // Next values of the datapath registers.
   always_comb begin
      in_in     = in_ff;
      s_in      = s_ff;
      p_in      = p_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      res_in    = res_ff;
      out_in    = out_ff;
      if (cmd.load_in) in_in = req_data;
      if (cmd.mul_smooth) begin
         prod_a_in = gain_prod;
         prod_b_in = keep_prod[47:0];
      end
      if (cmd.upd_smooth) s_in = smooth_sum[31:0];
      if (cmd.mul_peak)   prod_b_in = decay_prod;
      if (cmd.upd_peak)   p_in = (decayed < s_ff) ? s_ff : decayed;
      if (cmd.div_load) begin
         rem_in = mul_p[vepm_pkg::REM_W-1:0];
         dsh_in = {divisor, 6'h00};
         quo_in = '0;
      end
      if (cmd.div_step) begin
         if (fits) rem_in = rem_ff - dsh_ff;
         dsh_in = {1'b0, dsh_ff[vepm_pkg::REM_W-1:1]};
         quo_in = {quo_ff[5:0], fits};
      end
      if (cmd.div_store) begin
         unique case (cmd.sel)
            vepm_pkg::SEL_LEVEL:
               res_in.level_height = (p_ff == 32'h0) ? 6'h00 : quo_ff[5:0];
            vepm_pkg::SEL_BASS:   res_in.bass_bar   = bar;
            vepm_pkg::SEL_MID:    res_in.mid_bar    = bar;
            vepm_pkg::SEL_TREBLE: res_in.treble_bar = bar;
            default:              res_in = res_ff;
         endcase
      end
      if (cmd.rsp_load) begin
         out_in              = res_ff;
         out_in.smoothed_out = s_ff[31:16];
         out_in.peak_out     = p_ff[31:16];
      end
   end

   // Envelope and peak state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
         p_ff <= vepm_pkg::PEAK_RESET;
      end else begin
         s_ff <= s_in;
         p_ff <= p_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_ff     <= in_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

// ----- src/vu_envelope_peak_normalized_meter.sv -----
// Envelope follower with decaying peak, normalized meter height and band bars.
// A word is taken only in the idle state, reached again once its result is
// loaded, so words never overlap; the shared shift-subtract divider runs
// four divisions of seven steps each per word.
// Reset (synchronous): smoothed level 0, peak 0.01, registers to their defaults.
// Depends on vepm_pkg, vepm_csr, vepm_ctrl and vepm_dp.
module vu_envelope_peak_normalized_meter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  vepm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output vepm_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vepm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                      csr_data
);

   vepm_pkg::cfg_type cfg;
   vepm_pkg::cmd_type cmd;

   // Configuration registers.
   vepm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Sequencer and handshakes.
   vepm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic and state.
   vepm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
